// File: hdl/trn_pkg.sv
// ============================================================================
// trn_pkg: shared types, constants and arithmetic helpers
// Command and status types between the controller and the datapath, register
// indexes, the sine table builder and the saturating add helpers.
// ============================================================================
package trn_pkg;

    // Sizing constants
    localparam int MAX_SAMPLES      = 65536;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TRIG_AW          = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_W          = 16;
    localparam int TRIG_SHIFT       = PHASE_W - TRIG_AW;
    localparam int QUARTER_TURN     = SINE_TABLE_DEPTH / 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP = 2'd1;
    localparam logic [1:0] CFG_SAMPLES    = 2'd2;

    // Configuration reset values
    localparam logic [23:0] TIME_STEP_RST = 24'd16777;
    localparam logic [15:0] PHASE_STEP_RST = 16'd0;
    localparam logic [16:0] SAMPLES_RST   = 17'd1024;

    localparam logic [62:0] MAX63 = {63{1'b1}};

    typedef logic signed [16:0] trig_t;
    typedef trig_t trig_rom_t [SINE_TABLE_DEPTH];

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_RLO, ST_RHI, ST_RSUM,
        ST_E0, ST_E1, ST_E2, ST_E3, ST_E4,
        ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
        ST_SPEC, ST_EMIT
    } trn_state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RLO, OP_RHI, OP_RSUM,
        OP_E0, OP_E1, OP_E2, OP_E3, OP_E4,
        OP_B0, OP_B1, OP_B2, OP_B3, OP_B4, OP_B5, OP_B6,
        OP_Q0, OP_Q1, OP_Q2, OP_Q3, OP_Q4,
        OP_SPEC, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   sel;    // 0: cosine bin, 1: sine bin
    } trn_cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } trn_status_t;

    // Polynomial sine, Q15 result, phase in units of 2^-16 turn
    function automatic trig_t sin_q15(input logic [15:0] q);
        logic [1:0]  quad;
        logic [31:0] r;
        logic [31:0] u;
        logic [31:0] u2;
        logic [31:0] t;
        logic [31:0] p;
        logic signed [16:0] p17;
        quad = q[15:14];
        r    = {18'd0, q[13:0]};
        if (quad[0])
            r = 32'd16384 - r;
        u   = r << 1;
        u2  = (u * u) >> 15;
        t   = (32'd2385 * u2) >> 15;
        t   = 32'd21076 - t;
        t   = (t * u2) >> 15;
        t   = 32'd51459 - t;
        p   = (u * t) >> 15;
        p17 = p[16:0];
        return quad[1] ? -p17 : p17;
    endfunction

    // Sine table on the quantized phase grid
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t rom;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            rom[i] = sin_q15(PHASE_W'(i << TRIG_SHIFT));
        return rom;
    endfunction

    // floor(x / 2^23), saturated at 2^63-1
    function automatic logic [62:0] sat23(input logic [127:0] x);
        return (|x[127:86]) ? MAX63 : x[85:23];
    endfunction

    // Saturating unsigned add at 2^63-1
    function automatic logic [62:0] add63(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? MAX63 : s[62:0];
    endfunction

    // Saturating signed 64 bit add
    function automatic logic signed [63:0] add64s(input logic signed [63:0] a,
                                                  input logic signed [51:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {{13{b[51]}}, b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, MAX63};
        return s[63:0];
    endfunction

endpackage

// File: hdl/trn_ctrl.sv
// ============================================================================
// trn_ctrl: sequencer for the residual and norm datapath
// Steps one sample through the shared multiplier: residual scaling, energy,
// the cosine and sine bins, and at trace end the spectral magnitude.
// ============================================================================
module trn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output trn_pkg::trn_cmd_t  cmd,
    input  trn_pkg::trn_status_t status
);
    import trn_pkg::*;

    trn_state_t state_reg, state_next;
    logic       sel_reg, sel_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_RLO;
                end
            end
            ST_RLO:  begin cmd.op = OP_RLO;  state_next = ST_RHI;  end
            ST_RHI:  begin cmd.op = OP_RHI;  state_next = ST_RSUM; end
            ST_RSUM: begin cmd.op = OP_RSUM; state_next = ST_E0;   end
            ST_E0:   begin cmd.op = OP_E0;   state_next = ST_E1;   end
            ST_E1:   begin cmd.op = OP_E1;   state_next = ST_E2;   end
            ST_E2:   begin cmd.op = OP_E2;   state_next = ST_E3;   end
            ST_E3:   begin cmd.op = OP_E3;   state_next = ST_E4;   end
            ST_E4:   begin cmd.op = OP_E4;   state_next = ST_B0;   end
            ST_B0:   begin cmd.op = OP_B0;   state_next = ST_B1;   end
            ST_B1:   begin cmd.op = OP_B1;   state_next = ST_B2;   end
            ST_B2:   begin cmd.op = OP_B2;   state_next = ST_B3;   end
            ST_B3:   begin cmd.op = OP_B3;   state_next = ST_B4;   end
            ST_B4:   begin cmd.op = OP_B4;   state_next = ST_B5;   end
            ST_B5:   begin cmd.op = OP_B5;   state_next = ST_B6;   end
            ST_B6:
            begin
                cmd.op = OP_B6;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_B0;
                end
                else
                begin
                    sel_next   = 1'b0;
                    state_next = status.last ? ST_Q0 : ST_EMIT;
                end
            end
            ST_Q0:   begin cmd.op = OP_Q0;   state_next = ST_Q1;   end
            ST_Q1:   begin cmd.op = OP_Q1;   state_next = ST_Q2;   end
            ST_Q2:   begin cmd.op = OP_Q2;   state_next = ST_Q3;   end
            ST_Q3:   begin cmd.op = OP_Q3;   state_next = ST_Q4;   end
            ST_Q4:
            begin
                cmd.op = OP_Q4;
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = ST_Q0;
                end
                else
                begin
                    sel_next   = 1'b0;
                    state_next = ST_SPEC;
                end
            end
            ST_SPEC: begin cmd.op = OP_SPEC; state_next = ST_EMIT; end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_RLO))
        else $error("accepted beat did not start the sequence");
    a_spectral_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q0) |-> status.last)
        else $error("spectral pass on a sample that does not end a trace");
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && status.out_busy) |=> (state_reg == ST_EMIT))
        else $error("result dropped while output register was full");
    a_sel_back: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_B6 && sel_reg) |=> !sel_reg)
        else $error("bin select not returned to cosine");
`endif

endmodule

// File: hdl/trn_dpath.sv
// ============================================================================
// trn_dpath: residual and norm datapath
// Configuration registers, the integrator, one shared 33x33 multiplier with
// a product register, the sine table, the accumulators and the output stage.
// ============================================================================
module trn_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    input  trn_pkg::trn_cmd_t   cmd,
    output trn_pkg::trn_status_t status,
    input  logic signed [23:0]  synth_sample,
    input  logic signed [23:0]  observed_sample,
    input  logic                first_in_trace,
    input  logic                last_in_trace,
    input  logic                first_of_gather,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [47:0]  residual_value,
    output logic [16:0]         reversed_index,
    output logic [62:0]         energy_norm,
    output logic [62:0]         spectral_norm,
    output logic                spectral_valid
);
    import trn_pkg::*;

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

    // Configuration
    logic [23:0] ts_reg;
    logic [15:0] ps_reg;
    logic [16:0] ns_reg;

    // Running state
    logic signed [47:0] integ_reg;
    logic [16:0]        count_reg;
    logic signed [63:0] cos_sum_reg;
    logic signed [63:0] sin_sum_reg;
    logic [62:0]        energy_reg;
    logic [62:0]        spec_reg;
    logic               out_valid_reg;

    // Per-sample working registers
    logic [16:0]        rev_reg;
    logic               last_reg;
    logic [15:0]        phase_reg;
    trig_t              sin_reg;
    trig_t              cos_reg;
    logic signed [47:0] r_reg;
    logic [127:0]       sq_reg;
    logic signed [49:0] w_reg;
    logic signed [51:0] x_reg;
    logic [62:0]        term_reg;
    logic signed [65:0] prod_reg;

    // Output registers
    logic signed [47:0] res_out_reg;
    logic [16:0]        rev_out_reg;
    logic [62:0]        energy_out_reg;
    logic [62:0]        spec_out_reg;
    logic               spec_valid_reg;

    // Combinational helpers
    logic signed [24:0] diff;
    logic signed [47:0] integ_base;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_next;
    logic [16:0]        ns_clamp;
    logic [16:0]        cnt_base;
    logic [16:0]        rev_next;
    logic [16:0]        count_next;
    logic [32:0]        phase_prod;
    logic [TRIG_AW-1:0] sin_addr;
    logic [TRIG_AW-1:0] cos_addr;
    logic [47:0]        r_mag;
    logic signed [63:0] sum_sel;
    logic [63:0]        sum_mag;
    trig_t              trig_sel;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_next;

    // Integrate the sample difference, saturating to 48 bits
    always_comb
    begin
        diff       = {synth_sample[23], synth_sample} - {observed_sample[23], observed_sample};
        integ_base = first_in_trace ? '0 : integ_reg;
        integ_sum  = {integ_base[47], integ_base} + {{24{diff[24]}}, diff};
        if (integ_sum[48] != integ_sum[47])
            integ_next = integ_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            integ_next = integ_sum[47:0];
    end

    // Trace length, reversed index and sample count
    always_comb
    begin
        if (ns_reg == '0)
            ns_clamp = 17'd1;
        else if (ns_reg > 17'(MAX_SAMPLES))
            ns_clamp = 17'(MAX_SAMPLES);
        else
            ns_clamp = ns_reg;
        cnt_base = first_in_trace ? '0 : count_reg;
        rev_next = ns_clamp - cnt_base;
        if (last_in_trace)
            count_next = '0;
        else if (&cnt_base)
            count_next = cnt_base;
        else
            count_next = cnt_base + 17'd1;
    end

    // Phase and table addresses
    always_comb
    begin
        phase_prod = rev_reg * ps_reg;
        sin_addr   = phase_reg[PHASE_W-1 -: TRIG_AW];
        cos_addr   = sin_addr + TRIG_AW'(QUARTER_TURN);
    end

    // Magnitudes and bin select
    always_comb
    begin
        r_mag    = r_reg[47] ? 48'(-r_reg) : 48'(r_reg);
        sum_sel  = cmd.sel ? sin_sum_reg : cos_sum_reg;
        sum_mag  = sum_sel[63] ? 64'(-sum_sel) : 64'(sum_sel);
        trig_sel = cmd.sel ? sin_reg : cos_reg;
    end

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_RLO:
            begin
                mul_a = {9'd0, integ_reg[23:0]};
                mul_b = {9'd0, ts_reg};
            end
            OP_RHI:
            begin
                mul_a = {{9{integ_reg[47]}}, integ_reg[47:24]};
                mul_b = {9'd0, ts_reg};
            end
            OP_E0:
            begin
                mul_a = {9'd0, r_mag[23:0]};
                mul_b = {9'd0, r_mag[23:0]};
            end
            OP_E1:
            begin
                mul_a = {9'd0, r_mag[47:24]};
                mul_b = {9'd0, r_mag[23:0]};
            end
            OP_E2:
            begin
                mul_a = {9'd0, r_mag[47:24]};
                mul_b = {9'd0, r_mag[47:24]};
            end
            OP_B0:
            begin
                mul_a = {9'd0, r_reg[23:0]};
                mul_b = {{16{trig_sel[16]}}, trig_sel};
            end
            OP_B1:
            begin
                mul_a = {{9{r_reg[47]}}, r_reg[47:24]};
                mul_b = {{16{trig_sel[16]}}, trig_sel};
            end
            OP_B3:
            begin
                mul_a = {9'd0, w_reg[23:0]};
                mul_b = {9'd0, ts_reg};
            end
            OP_B4:
            begin
                mul_a = {{7{w_reg[49]}}, w_reg[49:24]};
                mul_b = {9'd0, ts_reg};
            end
            OP_Q0:
            begin
                mul_a = {1'b0, sum_mag[31:0]};
                mul_b = {1'b0, sum_mag[31:0]};
            end
            OP_Q1:
            begin
                mul_a = {1'b0, sum_mag[63:32]};
                mul_b = {1'b0, sum_mag[31:0]};
            end
            OP_Q2:
            begin
                mul_a = {1'b0, sum_mag[63:32]};
                mul_b = {1'b0, sum_mag[63:32]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Configuration, running sums and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= TIME_STEP_RST;
            ps_reg        <= PHASE_STEP_RST;
            ns_reg        <= SAMPLES_RST;
            integ_reg     <= '0;
            count_reg     <= '0;
            cos_sum_reg   <= '0;
            sin_sum_reg   <= '0;
            energy_reg    <= '0;
            spec_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:  ts_reg <= cfg_data;
                    CFG_PHASE_STEP: ps_reg <= cfg_data[15:0];
                    CFG_SAMPLES:    ns_reg <= cfg_data[16:0];
                    default:        ;
                endcase
            end

            case (cmd.op)
                OP_LOAD:
                begin
                    integ_reg <= integ_next;
                    count_reg <= count_next;
                    if (first_of_gather)
                    begin
                        energy_reg <= '0;
                        spec_reg   <= '0;
                    end
                    if (first_in_trace)
                    begin
                        cos_sum_reg <= '0;
                        sin_sum_reg <= '0;
                    end
                end
                OP_E4: energy_reg <= add63(energy_reg, sat23(sq_reg));
                OP_B6:
                begin
                    if (cmd.sel)
                        sin_sum_reg <= add64s(sin_sum_reg, x_reg);
                    else
                        cos_sum_reg <= add64s(cos_sum_reg, x_reg);
                end
                OP_SPEC:
                begin
                    spec_reg    <= add63(spec_reg, term_reg);
                    cos_sum_reg <= '0;
                    sin_sum_reg <= '0;
                end
                default: ;
            endcase

            // Set on a new result, drop when taken
            if (cmd.op == OP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and output payload
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD:
            begin
                rev_reg  <= rev_next;
                last_reg <= last_in_trace;
            end
            OP_RLO:  phase_reg <= phase_prod[15:0];
            OP_RHI:
            begin
                r_reg   <= {24'd0, prod_reg[47:24]};
                sin_reg <= TRIG_ROM[sin_addr];
                cos_reg <= TRIG_ROM[cos_addr];
            end
            OP_RSUM: r_reg  <= r_reg + $signed(prod_reg[47:0]);
            OP_E1:   sq_reg <= {64'd0, prod_reg[63:0]};
            OP_E2:   sq_reg <= sq_reg + ({64'd0, prod_reg[63:0]} << 25);
            OP_E3:   sq_reg <= sq_reg + ({64'd0, prod_reg[63:0]} << 48);
            OP_B1:   w_reg  <= 50'(prod_reg >>> 15);
            OP_B2:   w_reg  <= w_reg + 50'(prod_reg <<< 9);
            OP_B4:   x_reg  <= {28'd0, prod_reg[47:24]};
            OP_B5:   x_reg  <= x_reg + 52'(prod_reg);
            OP_Q1:   sq_reg <= {64'd0, prod_reg[63:0]};
            OP_Q2:   sq_reg <= sq_reg + ({64'd0, prod_reg[63:0]} << 33);
            OP_Q3:   sq_reg <= sq_reg + ({64'd0, prod_reg[63:0]} << 64);
            OP_Q4:
            begin
                if (cmd.sel)
                    term_reg <= add63(term_reg, sat23(sq_reg));
                else
                    term_reg <= sat23(sq_reg);
            end
            OP_EMIT:
            begin
                res_out_reg    <= r_reg;
                rev_out_reg    <= rev_reg;
                energy_out_reg <= energy_reg;
                spec_out_reg   <= spec_reg;
                spec_valid_reg <= last_reg;
            end
            default: ;
        endcase
    end

    assign status.last     = last_reg;
    assign status.out_busy = out_valid_reg & ~out_ready;

    assign out_valid      = out_valid_reg;
    assign residual_value = res_out_reg;
    assign reversed_index = rev_out_reg;
    assign energy_norm    = energy_out_reg;
    assign spectral_norm  = spec_out_reg;
    assign spectral_valid = spec_valid_reg;

endmodule

// File: hdl/trace_residual_norm.sv
// Flow: each accepted sample is stepped through the single shared 33x33
// multiplier before the next is taken; a sample that ends a trace also gets
// the extra spectral magnitude pass. The next sample is taken while a
// result waits in the output register.
// Reset: rst_n clears the integrator, count, bin sums and both norms, and
// loads time_step 16777, phase_step 0, samples_per_trace 1024.
// ============================================================================
// trace_residual_norm: integrated seismic residual with L2 and DFT-bin norms
// Per sample: scaled integrated residual, reversed index and energy norm;
// per trace: one DFT bin whose squared magnitude feeds a spectral norm.
// ============================================================================
module trace_residual_norm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] synth_sample,
    input  logic signed [23:0] observed_sample,
    input  logic               first_in_trace,
    input  logic               last_in_trace,
    input  logic               first_of_gather,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] residual_value,
    output logic [16:0]        reversed_index,
    output logic [62:0]        energy_norm,
    output logic [62:0]        spectral_norm,
    output logic               spectral_valid
);
    import trn_pkg::*;

    trn_cmd_t    cmd;
    trn_status_t status;

    trn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    trn_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .synth_sample    (synth_sample),
        .observed_sample (observed_sample),
        .first_in_trace  (first_in_trace),
        .last_in_trace   (last_in_trace),
        .first_of_gather (first_of_gather),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .residual_value  (residual_value),
        .reversed_index  (reversed_index),
        .energy_norm     (energy_norm),
        .spectral_norm   (spectral_norm),
        .spectral_valid  (spectral_valid)
    );

endmodule
